>>> sv/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg
// shared types, constants and pointer helpers for the sorted priority queue
// ----------------------------------------------------------------------------
package sspq_pkg;

    localparam int CAPACITY  = 16;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int PRIO_W    = 16;
    localparam int PAYLOAD_W = 16;
    localparam int STATUS_W  = 2;
    localparam int ENTRY_W   = PRIO_W + PAYLOAD_W;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [IDX_W:0]   t_wide;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_PUT,
        S_POP_RD,
        S_POP_DATA,
        S_RESP
    } t_state;

    typedef struct packed {
        logic                        operation;
        logic signed [PRIO_W-1:0]    priority_req;
        logic        [PAYLOAD_W-1:0] payload;
    } t_item;

    typedef struct packed {
        logic        [STATUS_W-1:0]  status;
        logic signed [PRIO_W-1:0]    served_prio;
        logic        [PAYLOAD_W-1:0] out_payload;
    } t_result;

    typedef struct packed {
        logic idle;
        logic done;
    } t_ctrl_status;

    // circular pointer step forwards
    function automatic t_idx wrap_inc(input t_idx p);
        return (p == t_idx'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    // circular pointer step backwards
    function automatic t_idx wrap_dec(input t_idx p);
        return (p == '0) ? t_idx'(CAPACITY - 1) : p - 1'b1;
    endfunction

endpackage

>>> sv/sspq_if.sv
// ----------------------------------------------------------------------------
// sspq_if
// request and response channels of the sorted priority queue
// ----------------------------------------------------------------------------
interface sspq_in_if import sspq_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic signed [PRIO_W-1:0]    priority_req;
    logic        [PAYLOAD_W-1:0] payload;

    modport source (output valid, operation, priority_req, payload, input ready);
    modport sink   (input valid, operation, priority_req, payload, output ready);
endinterface

interface sspq_out_if import sspq_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic        [STATUS_W-1:0]  status;
    logic signed [PRIO_W-1:0]    served_prio;
    logic        [PAYLOAD_W-1:0] out_payload;

    modport source (output valid, status, served_prio, out_payload, input ready);
    modport sink   (input valid, status, served_prio, out_payload, output ready);
endinterface

>>> sv/sspq_ctrl.sv
// ----------------------------------------------------------------------------
// sspq_ctrl
// sequencer, circular entry store and single priority comparator
// ----------------------------------------------------------------------------
module sspq_ctrl import sspq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  t_item        i_item,
    input  logic         i_out_free,
    output t_ctrl_status o_status,
    output t_result      o_result
);

    t_state r_state, n_state;
    t_idx   r_head,  n_head;
    t_cnt   r_count, n_count;
    t_idx   r_wptr,  n_wptr;
    t_idx   r_rptr,  n_rptr;
    t_cnt   r_rem,   n_rem;
    logic signed [PRIO_W-1:0]    r_prio,    n_prio;
    logic        [PAYLOAD_W-1:0] r_payload, n_payload;
    t_result r_res, n_res;

    logic [ENTRY_W-1:0] r_mem [CAPACITY];
    logic [ENTRY_W-1:0] r_rdata;

    logic               mem_we;
    t_idx               mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    t_idx               mem_raddr;

    t_wide tail_sum;
    t_idx  tail;
    logic  rd_greater;

    // slot just past the last stored entry
    assign tail_sum = t_wide'(r_head) + t_wide'(r_count);
    assign tail     = (tail_sum >= t_wide'(CAPACITY)) ?
                      t_idx'(tail_sum - t_wide'(CAPACITY)) : t_idx'(tail_sum);

    // the one comparator: stored entry against the new priority
    assign rd_greater = $signed(r_rdata[ENTRY_W-1 -: PRIO_W]) > r_prio;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wptr    <= n_wptr;
        r_rptr    <= n_rptr;
        r_rem     <= n_rem;
        r_prio    <= n_prio;
        r_payload <= n_payload;
        r_res     <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_wptr    = r_wptr;
        n_rptr    = r_rptr;
        n_rem     = r_rem;
        n_prio    = r_prio;
        n_payload = r_payload;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = r_wptr;
        mem_wdata = {r_prio, r_payload};
        mem_re    = 1'b0;
        mem_raddr = r_rptr;
        o_status  = '{idle: 1'b0, done: 1'b0};

        case (r_state)
            S_IDLE: begin
                o_status.idle = 1'b1;
                if (i_start) begin
                    n_res = '{status: ST_OK, served_prio: '0, out_payload: '0};
                    if (i_item.operation == OP_INSERT) begin
                        n_prio    = i_item.priority_req;
                        n_payload = i_item.payload;
                        if (r_count == t_cnt'(CAPACITY)) begin
                            n_res.status = ST_FULL;
                            n_state      = S_RESP;
                        end else if (r_count == '0) begin
                            mem_we    = 1'b1;
                            mem_waddr = tail;
                            mem_wdata = {i_item.priority_req, i_item.payload};
                            n_count   = r_count + 1'b1;
                            n_state   = S_RESP;
                        end else begin
                            n_wptr  = tail;
                            n_rptr  = wrap_dec(tail);
                            n_rem   = r_count;
                            n_state = S_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_POP_RD;
                        end
                    end
                end
            end
            S_RD: begin
                mem_re  = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (rd_greater) begin
                    // move the larger entry one slot towards the tail
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata;
                    n_wptr    = r_rptr;
                    n_rptr    = wrap_dec(r_rptr);
                    n_rem     = r_rem - 1'b1;
                    n_state   = (r_rem == t_cnt'(1)) ? S_PUT : S_RD;
                end else begin
                    mem_we  = 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = S_RESP;
                end
            end
            S_PUT: begin
                mem_we  = 1'b1;
                n_count = r_count + 1'b1;
                n_state = S_RESP;
            end
            S_POP_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_head;
                n_state   = S_POP_DATA;
            end
            S_POP_DATA: begin
                n_res.status      = ST_OK;
                n_res.served_prio = $signed(r_rdata[ENTRY_W-1 -: PRIO_W]);
                n_res.out_payload = r_rdata[PAYLOAD_W-1:0];
                n_head            = wrap_inc(r_head);
                n_count           = r_count - 1'b1;
                n_state           = S_RESP;
            end
            S_RESP: begin
                o_status.done = 1'b1;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_result = r_res;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(CAPACITY))
        else $error("entry count above capacity");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_RD) |-> (r_count != '0))
        else $error("pop read on empty store");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_CMP) |-> (r_rem != '0 && r_rem <= r_count))
        else $error("insert walk beyond stored entries");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_res.status == ST_FULL) |-> (r_count == t_cnt'(CAPACITY)))
        else $error("full status with free slots");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not add an entry");

endmodule

>>> sv/stable_sorted_priority_queue.sv
// insert: a read and a compare step per entry moved up; the new entry is written in the
//   compare step that ends the walk, in a put step if all moved up, or on accept if empty
// pop: a read step, then a data step; pop on empty or insert on full: straight to result
// next request word can be taken the cycle after the result word enters the output register
// the insert walk is paced by the single read port of the store and its one comparator
// synchronous active-low reset empties the queue; the entry store itself is not cleared
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// bounded priority queue, ascending priority, fifo order among equal priorities
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue import sspq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sspq_in_if.sink    i_req,
    sspq_out_if.source o_rsp
);

    // entries live in a circular store: pop advances the head, an insert walks
    // back from the tail moving larger entries up one slot until its place is found

    t_ctrl_status ctrl_status;
    t_result      ctrl_result;
    t_item        req_item;
    logic         start;
    logic         out_free;

    logic    r_out_valid, n_out_valid;
    t_result r_out,       n_out;

    assign req_item = '{operation:    i_req.operation,
                        priority_req: i_req.priority_req,
                        payload:      i_req.payload};

    // take a request word whenever the sequencer is idle and out of reset
    assign i_req.ready = ctrl_status.idle && i_rst_n;
    assign start       = i_req.valid && i_req.ready;

    // output register can load when empty or being drained this cycle
    assign out_free = !r_out_valid || o_rsp.ready;

    sspq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (req_item),
        .i_out_free (out_free),
        .o_status   (ctrl_status),
        .o_result   (ctrl_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        // finished result word moves across when the register is free
        if (ctrl_status.done && out_free) begin
            n_out_valid = 1'b1;
            n_out       = ctrl_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.served_prio = r_out.served_prio;
    assign o_rsp.out_payload = r_out.out_payload;

endmodule

>>> tb/sspq_order_checker.sv
// ----------------------------------------------------------------------------
// sspq_order_checker
// watches both channels, predicts each result word and compares it in order
// ----------------------------------------------------------------------------
module sspq_order_checker import sspq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sspq_in_if   i_req_mon,
    sspq_out_if  i_rsp_mon,
    output int   o_error_count,
    output int   o_pending
);

    // shadow of the sorted store, slot 0 served next
    logic signed [PRIO_W-1:0]    shadow_prio [CAPACITY];
    logic        [PAYLOAD_W-1:0] shadow_tag  [CAPACITY];
    int                          shadow_count = 0;

    t_result awaited_results[$];
    int      mismatch_count = 0;

    // apply one request word to the shadow store and return its result word
    function automatic t_result serve_request(input t_item w);
        t_result r;
        int      slot;
        r              = '0;
        r.status       = ST_OK;
        if (w.operation == OP_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // new entry goes behind every entry of lower or equal priority
                slot = 0;
                while (slot < shadow_count && shadow_prio[slot] <= w.priority_req)
                    slot++;
                for (int k = shadow_count; k > slot; k--) begin
                    shadow_prio[k] = shadow_prio[k-1];
                    shadow_tag[k]  = shadow_tag[k-1];
                end
                shadow_prio[slot] = w.priority_req;
                shadow_tag[slot]  = w.payload;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.served_prio = shadow_prio[0];
                r.out_payload = shadow_tag[0];
                for (int k = 1; k < shadow_count; k++) begin
                    shadow_prio[k-1] = shadow_prio[k];
                    shadow_tag[k-1]  = shadow_tag[k];
                end
                shadow_count--;
            end
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_item   w;
        if (!i_rst_n) begin
            awaited_results.delete();
            shadow_count = 0;
        end else begin
            // results first: a word leaving now belongs to an earlier request
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with nothing awaited: status %0d", i_rsp_mon.status);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("status", want.status, i_rsp_mon.status);
                    compare_field("served_prio", want.served_prio, i_rsp_mon.served_prio);
                    compare_field("out_payload", want.out_payload, i_rsp_mon.out_payload);
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                w.operation    = i_req_mon.operation;
                w.priority_req = i_req_mon.priority_req;
                w.payload      = i_req_mon.payload;
                awaited_results.push_back(serve_request(w));
            end
        end
        o_error_count <= mismatch_count;
        o_pending     <= awaited_results.size();
    end

endmodule

>>> tb/stable_sorted_priority_queue_test.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_test
// directed and random insert/pop traffic under several idling patterns,
// checked word by word against an in-order shadow of the sorted store
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_test;
    import sspq_pkg::*;

    // traffic phases, the receiver looks at this to place its long hold-off
    typedef enum {
        PH_DIRECTED,
        PH_FREE_RUN,
        PH_SENDER_IDLE,
        PH_TAKER_STALL,
        PH_BOTH_IDLE,
        PH_BACKPRESSURE
    } t_phase;

    // priorities that fill the queue in the directed part: extremes, ties, bit patterns
    localparam logic signed [PRIO_W-1:0] FILL_PRIO [CAPACITY] = '{
        16'sh0000, -16'sd32768, 16'sh7FFF, 16'sh0000, 16'sh0000, -16'sd1, 16'sd1, 16'sd5,
        16'sd5, 16'sd5, -16'sd32768, 16'sh7FFF, 16'sh5555, -16'sd21846, 16'sh0000, -16'sd2
    };

    localparam int LONG_HOLD   = 300;
    localparam int SETTLE_WAIT = 2 * CAPACITY + 8;

    logic clk   = 1'b0;
    logic rst_n;

    t_phase phase          = PH_DIRECTED;
    int     take_stall_pct = 0;
    int     send_idle_pct  = 0;
    int     error_count;
    int     pending;

    sspq_in_if  req_ch ();
    sspq_out_if rsp_ch ();

    stable_sorted_priority_queue dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    sspq_order_checker order_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_mon     (req_ch),
        .i_rsp_mon     (rsp_ch),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // word builders
    // ------------------------------------------------------------------------
    function automatic t_item make_word(input logic op, input logic signed [PRIO_W-1:0] prio,
                                        input logic [PAYLOAD_W-1:0] tag);
        t_item w;
        w.operation    = op;
        w.priority_req = prio;
        w.payload      = tag;
        return w;
    endfunction

    // mostly a narrow band of priorities so ties are common, sometimes the full range
    function automatic t_item random_word(input int insert_pct);
        t_item w;
        w.operation = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_POP;
        if ($urandom_range(3) == 0)
            w.priority_req = PRIO_W'($urandom);
        else
            w.priority_req = PRIO_W'(int'($urandom_range(6)) - 3);
        w.payload = PAYLOAD_W'($urandom);
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // sender: called in the step of a rising edge, returns in the step of acceptance
    // ------------------------------------------------------------------------
    task automatic send_word(input t_item w);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= w.operation;
        req_ch.priority_req <= w.priority_req;
        req_ch.payload      <= w.payload;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // stop offering and wait until every awaited result word has been taken
    task automatic drain;
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // random traffic in bursts: insert-heavy bursts reach full, pop-heavy ones reach empty
    task automatic run_phase(input t_phase p, input int idle_pct, input int stall_pct,
                             input int count);
        int burst_left;
        int insert_pct;
        phase          <= p;
        take_stall_pct <= stall_pct;
        send_idle_pct   = idle_pct;
        burst_left      = 0;
        insert_pct      = 50;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(8, 40);
                case ($urandom_range(2))
                    0: insert_pct = 20;
                    1: insert_pct = 50;
                    default: insert_pct = 80;
                endcase
            end
            burst_left--;
            send_word(random_word(insert_pct));
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off at the start of the
    // backpressure phase so the output word backs up and the input stalls
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (phase == PH_BACKPRESSURE && !hold_used) begin
                hold_left = LONG_HOLD;
                hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= take_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin
        logic [PAYLOAD_W-1:0] tag;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.operation    <= OP_INSERT;
        req_ch.priority_req <= '0;
        req_ch.payload      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // pop on an empty queue, with the largest priority and an all-ones payload in the ignored fields
        send_word(make_word(OP_POP, 16'sh7FFF, 16'hFFFF));
        // fill to capacity: extremes, ties kept in arrival order, alternating bit patterns
        for (int k = 0; k < CAPACITY; k++) begin
            if (k == 0)
                tag = 16'h0000;
            else if (k == 1)
                tag = 16'hFFFF;
            else
                tag = 16'h0100 + PAYLOAD_W'(k);
            send_word(make_word(OP_INSERT, FILL_PRIO[k], tag));
        end
        // insert on a full queue is refused
        send_word(make_word(OP_INSERT, -16'sd32768, 16'h0000));
        // serve a few, lowest priority first and oldest first among ties
        for (int k = 0; k < 7; k++)
            send_word(make_word(OP_POP, 16'sh0000, 16'h0000));
        drain();

        run_phase(PH_FREE_RUN,     0,  0,  300);
        run_phase(PH_SENDER_IDLE,  64, 0,  300);
        run_phase(PH_TAKER_STALL,  0,  64, 300);
        run_phase(PH_BOTH_IDLE,    17, 17, 250);
        run_phase(PH_BACKPRESSURE, 0,  0,  60);

        // a late stray word would show up as an unexpected result here
        repeat (SETTLE_WAIT) @(posedge clk);
        if (error_count == 0 && pending == 0) begin
            $display("stable_sorted_priority_queue_test: done, clean");
        end else begin
            $display("stable_sorted_priority_queue_test: done, errors");
        end
        $finish;
    end

    // hard stop, far beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("stable_sorted_priority_queue_test: done, errors");
        $finish;
    end

endmodule
